// ===== sv/avp_pkg.sv =====
// Shared constants, tables, command/status structs and arithmetic helpers
// for the autocorrelation pitch vocoder. No dependencies.
`default_nettype none
package avp_pkg;

	localparam int LAGS    = 128;
	localparam int RING    = 2 * LAGS;
	localparam int SW      = 24;
	localparam int FRAC    = SW - 1;
	localparam int LAG_W   = $clog2(LAGS);
	localparam int POS_W   = $clog2(RING);
	localparam int NOTE_W  = 7;
	localparam int NOTES   = 128;
	localparam int KEEP_W  = 16;
	localparam int ACC_W   = 32;
	localparam int ROOT_W  = 23;
	localparam int P44_SH  = 2 * FRAC - 44;
	localparam int OUT_SH  = 28 - FRAC;
	localparam int DRAIN_W = 2;
	localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(2);
	localparam logic [KEEP_W-1:0] LEAK_RST = 16'd65372;

	localparam logic [63:0] PI_Q30   = 64'd3373259426;
	localparam logic [63:0] SEMI_Q32 = 64'd255392046;
	localparam logic [63:0] TOP_STEP = 64'd647154683;

	typedef logic [15:0] win_tab_t [RING];
	typedef logic [31:0] pitch_tab_t [NOTES];

	typedef struct packed {
		logic             accept;
		logic             clr;
		logic             lag_issue;
		logic             ola_issue;
		logic             rs_start;
		logic             emit_rd;
		logic             emit_wr;
		logic [POS_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic wrap;
		logic rs_busy;
		logic out_busy;
	} sts_t;

	typedef enum logic [9:0] {
		S_CLR  = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_LAG  = 10'b0000000100,
		S_LDRN = 10'b0000001000,
		S_RS0  = 10'b0000010000,
		S_RSW  = 10'b0000100000,
		S_OLA  = 10'b0001000000,
		S_ODRN = 10'b0010000000,
		S_EMR  = 10'b0100000000,
		S_EMW  = 10'b1000000000
	} state_t;

	// sin^2 window by truncated series, symmetric about LAGS
	function automatic win_tab_t build_window();
		win_tab_t w;
		logic [63:0] one;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] b;
		logic [63:0] s;
		logic [63:0] v;
		one = 64'd1 << 30;
		for (int i = 0; i <= LAGS; i++) begin
			x  = PI_Q30 * 64'(i) / 64'(RING);
			x2 = (x * x + (64'd1 << 29)) >> 30;
			b  = one;
			b  = one - ((x2 * b) >> 30) / 64'd110;
			b  = one - ((x2 * b) >> 30) / 64'd72;
			b  = one - ((x2 * b) >> 30) / 64'd42;
			b  = one - ((x2 * b) >> 30) / 64'd20;
			b  = one - ((x2 * b) >> 30) / 64'd6;
			s  = (x * b) >> 30;
			v  = (s * s + (64'd1 << 43)) >> 44;
			if (v > 64'd65535) begin
				v = 64'd65535;
			end
			w[i] = v[15:0];
			if (i > 0 && i < LAGS) begin
				w[RING-i] = v[15:0];
			end
		end
		return w;
	endfunction

	// phase increments: top octave by semitone steps, lower octaves halved
	function automatic pitch_tab_t build_pitch();
		pitch_tab_t p;
		logic [63:0] top [12];
		logic [63:0] v;
		int d;
		int o;
		top[0] = TOP_STEP;
		for (int k = 1; k < 12; k++) begin
			top[k] = top[k-1] + ((top[k-1] * SEMI_Q32 + (64'd1 << 31)) >> 32);
		end
		for (int n = 0; n < NOTES; n++) begin
			d = 127 - n;
			o = d / 12;
			v = top[11 - d % 12];
			if (o > 0) begin
				v = (v + (64'd1 << (o - 1))) >> o;
			end
			p[n] = v[31:0];
		end
		return p;
	endfunction

	localparam win_tab_t   WINDOW = build_window();
	localparam pitch_tab_t PITCH  = build_pitch();
	localparam logic [31:0] STEP_RST = PITCH[60];

	function automatic logic signed [ACC_W-1:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[ACC_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/avp_in_if.sv =====
// Input channel: one sample beat with optional note-on.
// Depends on avp_pkg.
`default_nettype none
interface avp_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [avp_pkg::SW-1:0]     sample_in;
	logic                              note_valid;
	logic        [avp_pkg::NOTE_W-1:0] note_number;
	modport source(output valid, sample_in, note_valid, note_number, input ready);
	modport sink(input valid, sample_in, note_valid, note_number, output ready);
endinterface
`default_nettype wire

// ===== sv/avp_out_if.sv =====
// Output channel: one sample beat.
// Depends on avp_pkg.
`default_nettype none
interface avp_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [avp_pkg::SW-1:0] sample_out;
	modport source(output valid, sample_out, input ready);
	modport sink(input valid, sample_out, output ready);
endinterface
`default_nettype wire

// ===== sv/avp_rsqrt.sv =====
// Iterative 1/sqrt unit: root = isqrt(floor(2^62 / (max(r0,0) + 2^18))).
// Restoring divide one bit a cycle, then bitwise square root. Depends on avp_pkg.
`default_nettype none
module avp_rsqrt (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [avp_pkg::ACC_W-1:0]    r0,
	output logic                                     busy,
	output logic        [avp_pkg::ROOT_W-1:0]        root
);
	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(62);
	localparam int Q_W = 45;
	localparam int N_W = 46;
	localparam int D_W = 33;
	localparam int R_W = 34;

	logic             busy_q;
	logic             sq_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W-1:0]   d_q;
	logic [R_W-1:0]   rem_q;
	logic [Q_W-1:0]   quo_q;
	logic [N_W-1:0]   n_q;
	logic [N_W-1:0]   r_q;
	logic [N_W-1:0]   bit_q;

	logic [R_W-1:0]   rem_sh;
	logic             ge;
	logic [Q_W-1:0]   quo_n;
	logic [N_W-1:0]   rb;
	logic             take;

	always_comb begin
		rem_sh = {rem_q[R_W-2:0], (cnt_q == CNT_TOP)};
		ge     = rem_sh >= R_W'(d_q);
		quo_n  = {quo_q[Q_W-2:0], ge};
		rb     = r_q + bit_q;
		take   = n_q >= rb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sq_q   <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			sq_q   <= 1'b0;
			cnt_q  <= CNT_TOP;
		end else if (busy_q) begin
			if (!sq_q) begin
				if (cnt_q == '0) begin
					sq_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (bit_q == N_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= (r0 < 0 ? '0 : D_W'(r0)) + (D_W'(1) << 18);
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q && !sq_q) begin
			rem_q <= ge ? rem_sh - R_W'(d_q) : rem_sh;
			quo_q <= quo_n;
			if (cnt_q == '0) begin
				n_q   <= N_W'(quo_n);
				r_q   <= '0;
				bit_q <= N_W'(1) << 44;
			end
		end else if (busy_q) begin
			if (take) begin
				n_q <= n_q - rb;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = r_q[avp_pkg::ROOT_W-1:0];
endmodule
`default_nettype wire

// ===== sv/avp_dpath.sv =====
// Datapath: rings, lag sums, phase, lag-update and overlap-add pipelines,
// output register. Depends on avp_pkg and avp_rsqrt.
`default_nettype none
module avp_dpath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire avp_pkg::cmd_t                        cmd,
	output avp_pkg::sts_t                             sts,
	input  wire logic signed [avp_pkg::SW-1:0]        sample_in,
	input  wire logic                                 note_valid,
	input  wire logic        [avp_pkg::NOTE_W-1:0]    note_number,
	input  wire logic                                 keep_we,
	input  wire logic        [avp_pkg::KEEP_W-1:0]    keep_wdata,
	input  wire logic                                 out_ready,
	output logic                                      out_valid,
	output logic signed [avp_pkg::SW-1:0]             out_sample
);
	localparam int SW    = avp_pkg::SW;
	localparam int PW    = avp_pkg::POS_W;
	localparam int LW    = avp_pkg::LAG_W;
	localparam int AW    = avp_pkg::ACC_W;
	localparam int P_W   = 2 * SW;
	localparam int LK_W  = 50;
	localparam int E_W   = AW + 2;
	localparam logic signed [63:0] H15 = 64'sd1 <<< 15;
	localparam logic signed [63:0] H16 = 64'sd1 <<< 16;
	localparam logic signed [LK_W-1:0] T15 = LK_W'(64'sd1 <<< 15);
	localparam logic signed [P_W-1:0] P_HALF = P_W'(64'sd1 <<< (avp_pkg::P44_SH - 1));
	localparam logic signed [E_W-1:0] E_HALF = E_W'(64'sd1 <<< (avp_pkg::OUT_SH - 1));
	localparam logic signed [E_W-1:0] SMAX = E_W'((64'sd1 <<< (SW - 1)) - 1);
	localparam logic signed [E_W-1:0] SMIN = -SMAX - E_W'(1);
	localparam logic [PW-1:0] LAST_LAG = PW'(avp_pkg::LAGS - 1);

	// state
	logic [avp_pkg::KEEP_W-1:0] keep_q;
	logic [PW-1:0]              pos_q;
	logic [31:0]                phase_q;
	logic [31:0]                step_q;
	logic                       wrap_q;
	logic signed [SW-1:0]       x_q;
	logic signed [AW-1:0]       r0_q;
	logic                       out_valid_q;
	logic signed [SW-1:0]       out_q;

	// memories
	logic signed [SW-1:0] in_mem  [avp_pkg::RING];
	logic signed [AW-1:0] lag_mem [avp_pkg::LAGS];
	logic signed [AW-1:0] out_mem [avp_pkg::RING];
	logic signed [SW-1:0] in_rd_q;
	logic signed [AW-1:0] lag_rd_q;
	logic signed [AW-1:0] out_rd_q;

	// lag pipeline
	logic                   v_l1, v_l2, v_l3;
	logic [LW-1:0]          idx_l1, idx_l2, idx_l3;
	logic signed [P_W-1:0]  p_l2;
	logic signed [LK_W-1:0] lk_l2;
	logic signed [63:0]     q_l3;
	logic signed [LK_W-1:0] lk_l3;

	// overlap-add pipeline
	logic                   v_o1, v_o2, v_o3;
	logic [PW-1:0]          at_o1, at_o2, at_o3;
	logic [15:0]            w_o1;
	logic signed [LK_W-1:0] t_o2;
	logic signed [AW-1:0]   y_o2, y_o3;
	logic signed [63:0]     c_o3;

	logic [31:0]            step_n;
	logic [31:0]            phase_n;
	logic [LW-1:0]          lag_ra;
	logic [PW-1:0]          out_ra;
	logic [PW-1:0]          in_ra;
	logic signed [17:0]     keep_s;
	logic signed [17:0]     wgt_s;
	logic signed [P_W-1:0]  p_rnd;
	logic signed [63:0]     acc;
	logic signed [AW-1:0]   lag_res;
	logic signed [LK_W-1:0] t_rnd;
	logic signed [AW-1:0]   ola_res;
	logic signed [E_W-1:0]  e_rnd;
	logic                   rs_busy;
	logic [avp_pkg::ROOT_W-1:0] scale;

	avp_rsqrt u_rsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.rs_start),
		.r0     (r0_q),
		.busy   (rs_busy),
		.root   (scale)
	);

	always_comb begin
		step_n  = note_valid ? avp_pkg::PITCH[note_number] : step_q;
		phase_n = phase_q + step_n;
		in_ra   = pos_q - cmd.idx;
		out_ra  = cmd.ola_issue ? pos_q + cmd.idx : pos_q;
		if (cmd.ola_issue) begin
			lag_ra = (cmd.idx < LAST_LAG) ? LW'(LAST_LAG - cmd.idx) : LW'(cmd.idx - LAST_LAG);
		end else begin
			lag_ra = cmd.idx[LW-1:0];
		end
		keep_s  = $signed({2'b00, keep_q});
		wgt_s   = $signed(18'h10000 - {2'b00, keep_q});
		p_rnd   = (p_l2 + P_HALF) >>> avp_pkg::P44_SH;
		acc     = 64'(lk_l3) + ((q_l3 + H15) >>> 16);
		lag_res = avp_pkg::sat32((acc + H15) >>> 16);
		t_rnd   = (t_o2 + T15) >>> 16;
		ola_res = avp_pkg::sat32(64'(y_o3) + ((c_o3 + H16) >>> 17));
		e_rnd   = (E_W'(out_rd_q) + E_HALF) >>> avp_pkg::OUT_SH;
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (cmd.clr || cmd.accept) begin
			in_mem[cmd.clr ? cmd.idx : pos_q] <= cmd.clr ? '0 : sample_in;
		end
		in_rd_q <= in_mem[in_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr || v_l3) begin
			lag_mem[cmd.clr ? cmd.idx[LW-1:0] : idx_l3] <= cmd.clr ? '0 : lag_res;
		end
		lag_rd_q <= lag_mem[lag_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			out_mem[cmd.idx] <= '0;
		end else if (v_o3) begin
			out_mem[at_o3] <= ola_res;
		end else if (cmd.emit_wr) begin
			out_mem[pos_q] <= '0;
		end
		out_rd_q <= out_mem[out_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q      <= avp_pkg::LEAK_RST;
			pos_q       <= '0;
			phase_q     <= '0;
			step_q      <= avp_pkg::STEP_RST;
			wrap_q      <= 1'b0;
			out_valid_q <= 1'b0;
			v_l1 <= 1'b0; v_l2 <= 1'b0; v_l3 <= 1'b0;
			v_o1 <= 1'b0; v_o2 <= 1'b0; v_o3 <= 1'b0;
		end else begin
			if (keep_we) begin
				keep_q <= keep_wdata;
			end
			if (cmd.accept) begin
				step_q  <= step_n;
				phase_q <= phase_n;
				wrap_q  <= phase_n < step_n;
			end
			if (cmd.emit_wr) begin
				pos_q       <= pos_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			v_l1 <= cmd.lag_issue; v_l2 <= v_l1; v_l3 <= v_l2;
			v_o1 <= cmd.ola_issue; v_o2 <= v_o1; v_o3 <= v_o2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q <= sample_in;
		end
		if (v_l3 && idx_l3 == '0) begin
			r0_q <= lag_res;
		end
		if (cmd.emit_wr) begin
			out_q <= (e_rnd > SMAX) ? SW'(SMAX) : (e_rnd < SMIN) ? SW'(SMIN) : SW'(e_rnd);
		end
		// lag update stages
		idx_l1 <= cmd.idx[LW-1:0];
		idx_l2 <= idx_l1;
		idx_l3 <= idx_l2;
		p_l2   <= x_q * in_rd_q;
		lk_l2  <= lag_rd_q * keep_s;
		q_l3   <= p_rnd * wgt_s;
		lk_l3  <= lk_l2;
		// overlap-add stages
		at_o1  <= pos_q + cmd.idx;
		w_o1   <= avp_pkg::WINDOW[PW'(cmd.idx + 1'b1)];
		at_o2  <= at_o1;
		at_o3  <= at_o2;
		t_o2   <= lag_rd_q * $signed({1'b0, w_o1});
		y_o2   <= out_rd_q;
		y_o3   <= y_o2;
		c_o3   <= t_rnd * $signed({1'b0, scale});
	end

	assign sts.wrap     = wrap_q;
	assign sts.rs_busy  = rs_busy;
	assign sts.out_busy = out_valid_q;
	assign out_valid    = out_valid_q;
	assign out_sample   = out_q;
endmodule
`default_nettype wire

// ===== sv/avp_ctrl.sv =====
// Sequencer: clearing pass, lag sweep, scale, overlap-add sweep, emit.
// Depends on avp_pkg.
`default_nettype none
module avp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output avp_pkg::cmd_t      cmd,
	input  wire avp_pkg::sts_t sts
);
	localparam int PW = avp_pkg::POS_W;
	localparam logic [PW-1:0] CLR_LAST = PW'(avp_pkg::RING - 1);
	localparam logic [PW-1:0] LAG_LAST = PW'(avp_pkg::LAGS - 1);
	localparam logic [PW-1:0] OLA_LAST = PW'(avp_pkg::RING - 2);

	avp_pkg::state_t state_q;
	logic [PW-1:0]               idx_q;
	logic [avp_pkg::DRAIN_W-1:0] drn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= avp_pkg::S_CLR;
			idx_q   <= '0;
			drn_q   <= '0;
		end else begin
			case (state_q)
				avp_pkg::S_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == CLR_LAST) begin
						state_q <= avp_pkg::S_IDLE;
					end
				end
				avp_pkg::S_IDLE: begin
					idx_q <= '0;
					if (in_valid) begin
						state_q <= avp_pkg::S_LAG;
					end
				end
				avp_pkg::S_LAG: begin
					idx_q <= idx_q + 1'b1;
					drn_q <= '0;
					if (idx_q == LAG_LAST) begin
						state_q <= avp_pkg::S_LDRN;
					end
				end
				avp_pkg::S_LDRN: begin
					drn_q <= drn_q + 1'b1;
					if (drn_q == avp_pkg::DRAIN_LAST) begin
						state_q <= sts.wrap ? avp_pkg::S_RS0 : avp_pkg::S_EMR;
					end
				end
				avp_pkg::S_RS0: begin
					state_q <= avp_pkg::S_RSW;
				end
				avp_pkg::S_RSW: begin
					idx_q <= '0;
					if (!sts.rs_busy) begin
						state_q <= avp_pkg::S_OLA;
					end
				end
				avp_pkg::S_OLA: begin
					idx_q <= idx_q + 1'b1;
					drn_q <= '0;
					if (idx_q == OLA_LAST) begin
						state_q <= avp_pkg::S_ODRN;
					end
				end
				avp_pkg::S_ODRN: begin
					drn_q <= drn_q + 1'b1;
					if (drn_q == avp_pkg::DRAIN_LAST) begin
						state_q <= avp_pkg::S_EMR;
					end
				end
				avp_pkg::S_EMR: begin
					if (!sts.out_busy) begin
						state_q <= avp_pkg::S_EMW;
					end
				end
				avp_pkg::S_EMW: begin
					state_q <= avp_pkg::S_IDLE;
				end
				default: begin
					state_q <= avp_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		in_ready      = state_q == avp_pkg::S_IDLE;
		cmd.accept    = in_ready && in_valid;
		cmd.clr       = state_q == avp_pkg::S_CLR;
		cmd.lag_issue = state_q == avp_pkg::S_LAG;
		cmd.ola_issue = state_q == avp_pkg::S_OLA;
		cmd.rs_start  = state_q == avp_pkg::S_RS0;
		cmd.emit_rd   = (state_q == avp_pkg::S_EMR) && !sts.out_busy;
		cmd.emit_wr   = state_q == avp_pkg::S_EMW;
		cmd.idx       = idx_q;
	end
endmodule
`default_nettype wire

// ===== sv/autocorrelation_pitch_vocoder.sv =====
// Autocorrelation pitch vocoder, top level. Depends on avp_pkg, the channel
// interfaces, avp_ctrl and avp_dpath (with avp_rsqrt).
// An input beat is taken through the lag sweep, one issue per lag, the lag drain and the
// emit read and write; a phase wrap adds the 1/sqrt, the overlap-add sweep and its drain.
// One beat at a time: a new beat is accepted only once the last is emitted; dout stalls delay it.
// Reset: asynchronous; a clearing pass over every ring entry zeroes the rings and lags.
`default_nettype none
module autocorrelation_pitch_vocoder (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	avp_in_if.sink                            din,
	avp_out_if.source                         dout,
	input  wire logic                         cfg_we,
	input  wire logic [avp_pkg::KEEP_W-1:0]   cfg_wdata
);
	// command / status between sequencer and datapath
	avp_pkg::cmd_t cmd;
	avp_pkg::sts_t sts;

	avp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath holds every store; the output register decouples the
	// result beat from the next input beat
	avp_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample_in   (din.sample_in),
		.note_valid  (din.note_valid),
		.note_number (din.note_number),
		.keep_we     (cfg_we),
		.keep_wdata  (cfg_wdata),
		.out_ready   (dout.ready),
		.out_valid   (dout.valid),
		.out_sample  (dout.sample_out)
	);
endmodule
`default_nettype wire

// ===== dv/avp_tb_if.sv =====
// Testbench-side note: the block's channel interfaces live with the RTL (avp_in_if, avp_out_if).
// This file holds the stimulus beat type shared by the bench. Depends on avp_pkg.
`timescale 1ns / 100ps
package avp_tb_pkg;
	typedef struct packed {
		logic signed [avp_pkg::SW-1:0]     sample;
		logic                              note_on;
		logic        [avp_pkg::NOTE_W-1:0] note;
	} beat_t;
endpackage

// ===== dv/tb_autocorrelation_pitch_vocoder.sv =====
// Self-checking bench for the autocorrelation pitch vocoder: directed table then
// random beats, every output beat compared against an in-bench vocoder model.
// Depends on avp_pkg, avp_in_if, avp_out_if, avp_tb_pkg and the block RTL.
`timescale 1ns / 100ps
module tb_autocorrelation_pitch_vocoder;
	import avp_pkg::*;
	import avp_tb_pkg::*;

	localparam int CFG_KEEP = 0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [KEEP_W-1:0] cfg_wdata = '0;
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	bit failed = 1'b0;

	avp_in_if  din();
	avp_out_if dout();

	autocorrelation_pitch_vocoder dut (
		.clk(clk), .arst_n(arst_n), .din(din), .dout(dout),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---- vocoder model state ----
	logic signed [31:0] hist [RING];
	logic signed [31:0] lagr [LAGS];
	logic signed [31:0] ola [RING];
	logic [31:0] phase, step;
	logic [POS_W-1:0] wpos;
	logic [15:0] keep;
	logic [15:0] win [RING];
	logic [31:0] notes [NOTES];
	logic signed [SW-1:0] out_q[$];

	// arithmetic right shift with half-LSB rounding
	function automatic longint rnd_shr(longint v, int s);
		if (s == 0) return v;
		return (v + (64'sd1 << (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Hann window and pitch steps rebuilt independently from the series
	task automatic build_tables();
		longint unsigned one, x, x2, b, s, v, top [12];
		int divs [5];
		int d, o;
		divs = '{110, 72, 42, 20, 6};
		one = 64'd1 << 30;
		for (int i = 0; i <= LAGS; i++) begin
			x = 64'd3373259426 * i / (2 * LAGS);
			x2 = (x * x + (64'd1 << 29)) >> 30;
			b = one;
			for (int k = 0; k < 5; k++) b = one - ((x2 * b) >> 30) / divs[k];
			s = (x * b) >> 30;
			v = (s * s + (64'd1 << 43)) >> 44;
			if (v > 65535) v = 65535;
			win[i % RING] = v[15:0];
			if (i > 0 && i < LAGS) win[RING - i] = v[15:0];
		end
		top[0] = 64'd647154683;
		for (int k = 1; k < 12; k++)
			top[k] = top[k-1] + ((top[k-1] * 64'd255392046 + (64'd1 << 31)) >> 32);
		for (int n = 0; n < NOTES; n++) begin
			d = 127 - n;
			o = d / 12;
			v = top[11 - d % 12];
			if (o > 0) v = (v + (64'd1 << (o - 1))) >> o;
			notes[n] = v[31:0];
		end
	endtask

	task automatic model_reset();
		for (int i = 0; i < RING; i++) begin
			hist[i] = 0;
			ola[i] = 0;
		end
		for (int i = 0; i < LAGS; i++) lagr[i] = 0;
		phase = 0;
		step = notes[60];
		wpos = 0;
		keep = LEAK_RST;
	endtask

	function automatic void ola_add(int at, logic signed [31:0] r, logic [15:0] w,
			longint scale);
		longint t, c;
		t = rnd_shr(longint'(r) * longint'({1'b0, w}), 16);
		c = rnd_shr(t * scale, 17);
		ola[at] = clip32(longint'(ola[at]) + c);
	endfunction

	// one input beat through the vocoder; returns the output sample
	function automatic logic signed [SW-1:0] vocode(beat_t bt);
		longint x, p, acc, wgt, y, scale;
		longint unsigned den;
		int idx, wy;
		x = bt.sample;
		wgt = 65536 - longint'(keep);
		if (bt.note_on) step = notes[bt.note];
		hist[wpos] = 32'(x);
		for (int l = 0; l < LAGS; l++) begin
			idx = (int'(wpos) + RING - l) % RING;
			p = rnd_shr(x * longint'(hist[idx]), 2 * FRAC - 44);
			acc = longint'(lagr[l]) * longint'(keep) + rnd_shr(p * wgt, 16);
			lagr[l] = clip32(rnd_shr(acc, 16));
		end
		phase = phase + step;
		if (phase < step) begin
			den = (lagr[0] < 0 ? 0 : longint'(lagr[0])) + 262144;
			scale = int_sqrt((64'd1 << 62) / den);
			wy = wpos;
			for (int k = 1; k < LAGS; k++) begin
				ola_add(wy, lagr[LAGS - k], win[k], scale);
				wy = (wy + 1) % RING;
			end
			for (int k = 0; k < LAGS; k++) begin
				ola_add(wy, lagr[k], win[k + LAGS], scale);
				wy = (wy + 1) % RING;
			end
		end
		y = rnd_shr(ola[wpos], 28 - FRAC);
		if (y > 8388607) y = 8388607;
		if (y < -8388608) y = -8388608;
		ola[wpos] = 0;
		wpos = wpos + 1'b1;
		return y[SW-1:0];
	endfunction

	// ---- sender ----
	initial begin
		din.valid = 1'b0;
		din.sample_in = '0;
		din.note_valid = 1'b0;
		din.note_number = '0;
	end

	// hands a beat over at the rising edge; predicts on acceptance
	task automatic send_beat(beat_t bt);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid <= 1'b1;
		din.sample_in <= bt.sample;
		din.note_valid <= bt.note_on;
		din.note_number <= bt.note;
		@(posedge clk);
		while (!din.ready) @(posedge clk);
		out_q.push_back(vocode(bt));
	endtask

	task automatic drain_out();
		din.valid <= 1'b0;
		while (out_q.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_keep(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		keep = v;
	endtask

	function automatic beat_t rand_beat();
		beat_t bt;
		case ($urandom_range(3))
			0: bt.sample = $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
			1: bt.sample = 24'($signed(24'($urandom_range(4095))) - 2048);
			default: bt.sample = 24'($urandom);
		endcase
		bt.note_on = ($urandom_range(15) == 0);
		// mostly high notes so phase wraps, and overlap-add, come often
		bt.note = $urandom_range(3) != 0 ? 7'($urandom_range(127, 90)) : 7'($urandom);
		return bt;
	endfunction

	// ---- receiver: random stalls, check each beat against the oldest prediction
	initial begin
		dout.ready = 1'b0;
	end
	always @(posedge clk) begin
		if (arst_n) begin
			if (dout.valid && dout.ready) begin
				if (out_q.size() == 0) begin
					$error("unexpected output beat sample_out=%0d", dout.sample_out);
					failed = 1'b1;
				end else begin
					if (dout.sample_out !== out_q[0]) begin
						$error("sample_out: expected %0d, actual %0d",
							out_q[0], dout.sample_out);
						failed = 1'b1;
					end
					void'(out_q.pop_front());
				end
			end
			dout.ready <= !(recv_idle != 0 && $urandom_range(99) < recv_idle);
		end
	end

	// directed rows; check_on marks an output read straight off the model
	typedef struct {
		beat_t             bt;
		bit                check_on;
		logic signed [SW-1:0] want;
	} row_t;
	row_t rows [$];

	initial begin
		int unsigned idle_plan [3][2];
		beat_t bt;
		idle_plan = '{'{35, 77}, '{77, 35}, '{0, 0}};
		build_tables();
		model_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the output ring is empty: the first beats come out as zero
		rows.push_back('{'{24'sh7fffff, 1'b0, 7'd0}, 1'b1, 24'sd0});
		rows.push_back('{'{24'sh800000, 1'b0, 7'd0}, 1'b1, 24'sd0});
		rows.push_back('{'{24'sh000000, 1'b1, 7'd127}, 1'b0, 24'sd0});
		rows.push_back('{'{24'sh000001, 1'b1, 7'd0}, 1'b0, 24'sd0});
		rows.push_back('{'{24'shffffff, 1'b1, 7'd127}, 1'b0, 24'sd0});
		for (int i = 0; i < 8; i++)
			rows.push_back('{'{24'sh7fffff, 1'b0, 7'h55}, 1'b0, 24'sd0});
		for (int i = 0; i < 8; i++)
			rows.push_back('{'{(i % 2) ? 24'sh800000 : 24'sh555555, 1'b0, 7'h2a},
				1'b0, 24'sd0});
		rows.push_back('{'{24'sh2aaaaa, 1'b1, 7'd60}, 1'b0, 24'sd0});
		foreach (rows[i]) begin
			send_beat(rows[i].bt);
			if (rows[i].check_on && out_q[$] !== rows[i].want) begin
				$error("sample_out: expected %0d, actual %0d (model)", rows[i].want, out_q[$]);
				failed = 1'b1;
			end
		end
		// hold the sender until every beat is back, then move to the retention extremes
		drain_out();
		write_keep(16'd0);
		for (int i = 0; i < 20; i++) send_beat(rand_beat());
		drain_out();
		write_keep(16'hffff);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = idle_plan[ph][0];
			recv_idle = idle_plan[ph][1];
			for (int i = 0; i < 380; i++) send_beat(rand_beat());
			drain_out();
			write_keep(ph == 2 ? LEAK_RST : 16'($urandom));
		end
		send_idle = 0;
		recv_idle = 0;
		for (int i = 0; i < 10; i++) send_beat(rand_beat());
		drain_out();
		if (failed || out_q.size() != 0) begin
			$display("tb_autocorrelation_pitch_vocoder: errors");
		end else begin
			$display("tb_autocorrelation_pitch_vocoder: clean");
		end
		$finish;
	end

	// watchdog: covers ~1200 beats with stalls, several times over
	initial begin
		#200ms;
		$display("tb_autocorrelation_pitch_vocoder: errors");
		$finish;
	end
endmodule

// ===== files.f =====
sv/avp_pkg.sv
sv/avp_in_if.sv
sv/avp_out_if.sv
sv/avp_rsqrt.sv
sv/avp_dpath.sv
sv/avp_ctrl.sv
sv/autocorrelation_pitch_vocoder.sv
dv/avp_tb_if.sv
dv/tb_autocorrelation_pitch_vocoder.sv
